### rtl/core/lpmd_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
`default_nettype none

package lpmd_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 32;
	localparam int COUNT_W = 32;
	localparam int HIGH_W  = 24;
	localparam int STAT_W  = 3;

	// Position within the frame header and payload.
	typedef enum logic [2:0] {
		PH_FLAG = 3'd0,
		PH_LEN0 = 3'd1,
		PH_LEN1 = 3'd2,
		PH_LEN2 = 3'd3,
		PH_LEN3 = 3'd4,
		PH_DATA = 3'd5
	} phase_t;

	// Status code reported with every result.
	typedef enum logic [STAT_W-1:0] {
		ST_HEADER   = 3'd0,
		ST_PAYLOAD  = 3'd1,
		ST_BADFLAGS = 3'd2,
		ST_OVERSIZE = 3'd3,
		ST_HALTED   = 3'd4
	} status_t;

	// Decoder state carried from byte to byte.
	typedef struct packed {
		phase_t             phase;
		logic               compressed;
		logic [HIGH_W-1:0]  length_high;
		logic [LEN_W-1:0]   declared_length;
		logic [LEN_W-1:0]   bytes_remaining;
		logic [COUNT_W-1:0] frames_seen;
		logic               halted;
	} dec_state_t;

	// One result, as it leaves on the master side.
	typedef struct packed {
		status_t            status;
		logic [BYTE_W-1:0]  payload_byte;
		logic               compressed;
		logic [LEN_W-1:0]   msg_length;
		logic               message_end;
		logic [COUNT_W-1:0] frame_count;
	} dec_result_t;

	localparam dec_state_t STATE_RESET = '{
		phase:           PH_FLAG,
		compressed:      1'b0,
		length_high:     '0,
		declared_length: '0,
		bytes_remaining: '0,
		frames_seen:     '0,
		halted:          1'b0
	};

endpackage

`default_nettype wire

### rtl/core/lpmd_step.sv
// Next-state and result logic for one byte of the framed stream.
`default_nettype none

module lpmd_step
	import lpmd_pkg::*;
(
	input  wire dec_state_t        cur,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [LEN_W-1:0]  max_frame_length,
	output dec_state_t             nxt,
	output dec_result_t            res
);

	logic [LEN_W-1:0] full_len;
	logic [LEN_W-1:0] remaining_dec;
	logic             end_mark;

	assign full_len      = {cur.length_high, data_byte};
	assign remaining_dec = cur.bytes_remaining - LEN_W'(1);

	// Decode one byte against the current header/payload position.
	always_comb begin
		nxt              = cur;
		end_mark         = 1'b0;
		res.status       = ST_HEADER;
		res.payload_byte = '0;
		if (cur.halted) begin
			res.status = ST_HALTED;
		end else begin
			case (cur.phase)
				PH_LEN0: begin
					nxt.length_high = {cur.length_high[HIGH_W-BYTE_W-1:0], data_byte};
					nxt.phase       = PH_LEN1;
				end
				PH_LEN1: begin
					nxt.length_high = {cur.length_high[HIGH_W-BYTE_W-1:0], data_byte};
					nxt.phase       = PH_LEN2;
				end
				PH_LEN2: begin
					nxt.length_high = {cur.length_high[HIGH_W-BYTE_W-1:0], data_byte};
					nxt.phase       = PH_LEN3;
				end
				PH_LEN3: begin
					nxt.declared_length = full_len;
					nxt.length_high     = '0;
					if (max_frame_length != '0 && full_len > max_frame_length) begin
						res.status = ST_OVERSIZE;
						nxt.halted = 1'b1;
					end else if (full_len == '0) begin
						end_mark = 1'b1;
					end else begin
						nxt.bytes_remaining = full_len;
						nxt.phase           = PH_DATA;
					end
				end
				PH_DATA: begin
					res.status          = ST_PAYLOAD;
					res.payload_byte    = data_byte;
					nxt.bytes_remaining = remaining_dec;
					end_mark            = (remaining_dec == '0);
				end
				default: begin
					// Flags byte: only the compressed bit may be set.
					if (data_byte[BYTE_W-1:1] != '0) begin
						res.status          = ST_BADFLAGS;
						nxt.halted          = 1'b1;
						nxt.compressed      = 1'b0;
						nxt.declared_length = '0;
					end else begin
						nxt.compressed      = data_byte[0];
						nxt.declared_length = '0;
						nxt.length_high     = '0;
						nxt.frames_seen     = cur.frames_seen + COUNT_W'(1);
						nxt.phase           = PH_LEN0;
					end
				end
			endcase
			// A finished message clears the per-message fields after reporting them.
			if (end_mark) begin
				nxt.compressed      = 1'b0;
				nxt.declared_length = '0;
				nxt.bytes_remaining = '0;
				nxt.phase           = PH_FLAG;
			end
		end
		res.compressed     = cur.halted ? cur.compressed : (end_mark ? cur.compressed
		                                                             : nxt.compressed);
		res.msg_length     = cur.halted ? cur.declared_length
		                                : (end_mark ? (cur.phase == PH_LEN3 ? full_len
		                                                                    : cur.declared_length)
		                                            : nxt.declared_length);
		res.message_end    = end_mark;
		res.frame_count    = nxt.frames_seen;
	end

endmodule

`default_nettype wire

### rtl/core/length_prefixed_message_deframer_core.sv
// Top level of the length-prefixed message deframer.
`default_nettype none

// Length-prefixed message deframer. Each byte taken on the slave side yields
// exactly one result on the master side: a status, the payload byte, the
// compressed flag and declared length of the current message, an end-of-message
// mark on m_tlast and a running count of accepted frame headers. A message is a
// flags byte, a big-endian 32-bit length and that many payload bytes; an empty
// message ends on its last length byte. A flags byte with any bit other than
// bit 0 set, or a length above a nonzero max_frame_length, is an error, after
// which every byte reports the halted status until reset. The block takes one
// byte per cycle when the master side is not stalled; a byte accepted into the
// input register is decoded into the result register once that register is free
// and can be taken on the master side from then on (one input register, one result register).
// The one-cycle rate is set by the per-byte update of the header state, which
// is 32-bit compares against the limit and zero and a decrement between the two registers.
module length_prefixed_message_deframer_core
	import lpmd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: max_frame_length, zero means no limit.
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	// Input stream. tdata: [7:0] data_byte.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: [7:0] payload_byte, [39:8] msg_length, [71:40] frame_count.
	output logic [71:0]      m_tdata,
	// tuser: [2:0] status, [3] compressed.
	output logic [3:0]       m_tuser,
	output logic             m_tlast
);

	logic [LEN_W-1:0]  max_len_q;
	dec_state_t        state_q;
	dec_state_t        state_nxt;
	dec_result_t       step_res;
	dec_result_t       res_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              advance;
	logic              step_en;

	// The result register frees up when empty or when its request is taken.
	assign advance  = !out_valid_q || m_tready;
	assign step_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '0;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	lpmd_step u_step (
		.cur              (state_q),
		.data_byte        (byte_s1),
		.max_frame_length (max_len_q),
		.nxt              (state_nxt),
		.res              (step_res)
	);

	// Decoder state moves on only when a byte passes into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= step_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.frame_count, res_q.msg_length, res_q.payload_byte};
	assign m_tuser  = {res_q.compressed, res_q.status};
	assign m_tlast  = res_q.message_end;

	// Once halted, the decoder stays halted until reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted |=> state_q.halted)
		else $error("decoder left the halted state");

	// The frame counter only moves when a byte is decoded.
	assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(state_q.frames_seen))
		else $error("frame count changed without a decoded byte");

	// A message can only end on a header or payload byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			(m_tuser[2:0] == ST_HEADER || m_tuser[2:0] == ST_PAYLOAD))
		else $error("message end reported with an error status");

	// Error statuses come only from an unhalted decoder and halt it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && !state_q.halted &&
			(step_res.status == ST_BADFLAGS || step_res.status == ST_OVERSIZE))
		|=> state_q.halted)
		else $error("error status without halting");

endmodule

`default_nettype wire
